// File: design/spq_pkg.sv
package spq_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] in_priority;
    logic signed [31:0] in_value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] out_priority;
    logic signed [31:0] out_value;
    logic [7:0]         occupancy;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] pri;
    logic signed [31:0] val;
  } entry_t;

  // Broadcast to every cell in the chain
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t new_entry;
  } spq_ctl_t;

endpackage

// File: design/spq_cell.sv
module spq_cell (
  input  logic              clk,
  input  spq_pkg::spq_ctl_t ctl,
  input  logic              occupied,
  input  logic              left_ge,
  input  spq_pkg::entry_t   left_entry,
  input  spq_pkg::entry_t   right_entry,
  output logic              ge,
  output spq_pkg::entry_t   entry
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // Held entry stays ahead of the new one on equal priority
  assign ge    = occupied && (entry_r.pri >= ctl.new_entry.pri);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (ge) begin
        entry_nxt = entry_r;
      end else if (left_ge) begin
        entry_nxt = ctl.new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (ctl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: design/sorted_priority_queue.sv
// The result of each accepted transaction is registered in the output register.
// Throughput: one insert or pop per cycle while ready is high; each cell of the
// chain compares its entry with the broadcast priority and shifts.
// Ready drops only while a finished result is held and not taken.
// Reset (rst_n low, synchronous): entry count and output valid cleared;
// slot contents are left as they are.
module sorted_priority_queue #(
  parameter int DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  spq_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output spq_pkg::out_item_t  out_data
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  out_item_t     out_data_r;
  out_item_t     result;

  logic          accept;
  logic          full;
  logic          empty;
  spq_ctl_t      ctl;

  logic   [DEPTH-1:0] ge;
  entry_t             cell_entry [DEPTH];
  logic [CW+7:0]      count_ext;

  assign accept = in_valid && in_ready;
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);

  always_comb begin
    ctl.ins           = accept && (in_data.op == OP_INSERT) && !full;
    ctl.pop           = accept && (in_data.op == OP_POP) && !empty;
    ctl.new_entry.pri = in_data.in_priority;
    ctl.new_entry.val = in_data.in_value;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic   occ;
    logic   lge;
    entry_t lent;
    entry_t rent;

    assign occ = (IDX < count_r);

    if (i == 0) begin : g_head
      assign lge  = 1'b1;
      assign lent = ctl.new_entry;
    end else begin : g_body
      assign lge  = ge[i-1];
      assign lent = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rent = cell_entry[i];
    end else begin : g_inner
      assign rent = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ),
      .left_ge     (lge),
      .left_entry  (lent),
      .right_entry (rent),
      .ge          (ge[i]),
      .entry       (cell_entry[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign count_ext = {8'd0, count_nxt};

  always_comb begin
    result.status       = ST_OK;
    result.out_priority = '0;
    result.out_value    = '0;
    result.occupancy    = count_ext[7:0];
    if (in_data.op == OP_INSERT) begin
      if (full) begin
        result.status = ST_FULL;
      end
    end else begin
      if (empty) begin
        result.status = ST_EMPTY;
      end else begin
        result.out_priority = cell_entry[0].pri;
        result.out_value    = cell_entry[0].val;
      end
    end
  end

  assign in_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/spq_checker.sv
module spq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input spq_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input spq_pkg::out_item_t out_data
);
  import spq_pkg::*;

  // Output register clears on reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Held result blocks new transactions
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

  // An insert transaction returns a zero payload on the next cycle
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == OP_INSERT |=>
      out_valid && out_data.out_priority == 0 && out_data.out_value == 0)
    else $error("non-zero payload on insert");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.occupancy == 8'd0)
    else $error("empty status with non-zero occupancy");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
